>>> sv/cohort_batched_lock_arbiter_top_defines.svh
// Assertion macros used by the cohort lock arbiter top level.
`ifndef COHORT_BATCHED_LOCK_ARBITER_TOP_DEFINES_SVH
`define COHORT_BATCHED_LOCK_ARBITER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBLA_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error("cohort lock arbiter: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CBLA_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error("cohort lock arbiter: assertion failed");

`endif

>>> sv/cbla_pkg.sv
// Types, codes and helper functions of the cohort lock arbiter.
`default_nettype none

package cbla_pkg;

	localparam int TID_W     = 6;
	localparam int MB_W      = 8;
	localparam int NCOH_W    = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_BATCH_LIM   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COHORTS = 1'b1;

	localparam logic OP_LOCK   = 1'b0;
	localparam logic OP_UNLOCK = 1'b1;

	localparam logic [2:0] OUT_QUEUED     = 3'd0;
	localparam logic [2:0] OUT_GRANTED    = 3'd1;
	localparam logic [2:0] OUT_UNLOCKED   = 3'd2;
	localparam logic [2:0] OUT_NON_HOLDER = 3'd3;
	localparam logic [2:0] OUT_DUPLICATE  = 3'd4;

	// Remainder unit: bits of the thread id consumed per cycle
	localparam int MOD_STEP  = 3;
	localparam int MOD_CYC   = TID_W / MOD_STEP;
	localparam int MOD_CNT_W = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

	typedef struct packed {
		logic             operation;
		logic [TID_W-1:0] req_thread;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       outcome;
		logic             grant_valid;
		logic [TID_W-1:0] grant_thread;
		logic             local_handoff;
	} out_item_t;

	typedef struct packed {
		logic [MB_W-1:0]  batch;
		logic [TID_W-1:0] head;
		logic [TID_W-1:0] tail;
	} coh_entry_t;

	typedef enum logic [2:0] {
		EX_DUP,
		EX_GRANT,
		EX_QUEUE,
		EX_NON_HOLDER,
		EX_LOCAL,
		EX_RELEASE
	} ex_kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_CRD,
		S_EXEC,
		S_GRD,
		S_GCHK,
		S_GENT,
		S_POP,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic coh_rd;
		logic exec;
		logic gq_rd;
		logic gq_chk;
		logic link_rd;
		logic pop;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic     mod_done;
		ex_kind_t ex_kind;
		logic     gq_empty;
		logic     gd_ok;
		logic     out_free;
	} dp_status_t;

	// One restoring step of the remainder: shift in a bit, subtract if it fits.
	function automatic logic [NCOH_W-1:0] mod_step(input logic [NCOH_W-1:0] r,
			input logic b, input logic [NCOH_W-1:0] n);
		logic [NCOH_W:0] x;
		x = {r, b};
		if (x >= {1'b0, n}) begin
			x = x - {1'b0, n};
		end
		return x[NCOH_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> sv/cbla_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cbla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire              clk,
	input  wire              we,
	input  wire [AW-1:0]     waddr,
	input  wire [WIDTH-1:0]  wdata,
	input  wire              re,
	input  wire [AW-1:0]     raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> sv/cbla_ctrl.sv
// Controller state machine of the cohort lock arbiter.
`default_nettype none

module cbla_ctrl import cbla_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	output dp_cmd_t         cmd,
	input  wire dp_status_t status
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_n = S_MOD;
			end
			S_MOD: begin
				if (status.mod_done) state_n = S_CRD;
			end
			S_CRD: state_n = S_EXEC;
			S_EXEC: begin
				case (status.ex_kind)
					EX_LOCAL:   state_n = S_POP;
					EX_RELEASE: state_n = S_GRD;
					default:    state_n = S_OUT;
				endcase
			end
			S_GRD: begin
				state_n = status.gq_empty ? S_OUT : S_GCHK;
			end
			// skip cohorts that have drained since they were queued
			S_GCHK: begin
				state_n = status.gd_ok ? S_GENT : S_GRD;
			end
			S_GENT: state_n = S_POP;
			S_POP:  state_n = S_OUT;
			S_OUT: begin
				if (status.out_free) state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_MOD:  cmd.mod_step = 1'b1;
			S_CRD:  cmd.coh_rd   = 1'b1;
			S_EXEC: cmd.exec     = 1'b1;
			S_GRD:  cmd.gq_rd    = 1'b1;
			S_GCHK: cmd.gq_chk   = 1'b1;
			S_GENT: cmd.link_rd  = 1'b1;
			S_POP:  cmd.pop      = 1'b1;
			S_OUT:  cmd.out_load = status.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/cbla_dp.sv
// Datapath of the cohort lock arbiter: config, lock state, queues and result register.
`default_nettype none

module cbla_dp import cbla_pkg::*; #(
	parameter int MAX_THREADS = 64,
	parameter int MAX_COHORTS = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_valid,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [CFG_DAT_W-1:0] cfg_data,
	input  wire in_item_t       in_item,
	input  wire dp_cmd_t        cmd,
	output dp_status_t          status,
	output logic                out_valid,
	input  wire                 out_ready,
	output out_item_t           out_item
);

	// thread ids are TID_W bits wide, so no more entries are reachable
	localparam int NTHR = (MAX_THREADS < (1 << TID_W)) ? MAX_THREADS : (1 << TID_W);
	localparam int TAW  = $clog2(NTHR);
	localparam int CW   = (MAX_COHORTS > 1) ? $clog2(MAX_COHORTS) : 1;
	localparam int CNTW = $clog2(MAX_COHORTS + 1);
	localparam int SW   = CW + 1;

	logic [MB_W-1:0]      batch_lim_q;
	logic [NCOH_W-1:0]    num_coh_q;
	logic [NCOH_W-1:0]    n_eff;

	logic                 op_q;
	logic [TID_W-1:0]     tid_q;
	logic [TID_W-1:0]     divt_q, divh_q;
	logic [NCOH_W-1:0]    rt_q, rh_q, rt_n, rh_n;
	logic [MOD_CNT_W-1:0] mod_cnt_q;

	logic                 hv_q;
	logic [TID_W-1:0]     ht_q;
	logic [NTHR-1:0]      queued_q;
	logic [MAX_COHORTS-1:0] ne_q, bcv_q;

	logic [CW-1:0]        grp_q, grp_n, wp;
	logic [CNTW-1:0]      gcnt_q;
	logic [SW-1:0]        wsum;

	logic [CW-1:0]        coh_c, coh_h, coh_d, pop_coh_q;
	logic                 pop_local_q;
	logic [TAW-1:0]       tidx;

	coh_entry_t           coh_rd, coh_wr;
	logic                 coh_we, coh_re;
	logic [CW-1:0]        coh_waddr, coh_raddr;
	logic [TID_W-1:0]     link_rd;
	logic                 link_we, link_re;
	logic                 gq_we, gq_re;
	logic [CW-1:0]        gq_rd_data;

	logic                 t_bad, is_holder, ne_c, gq_full, gq_empty, gd_ok, out_free;
	logic [MB_W-1:0]      batch_c, batch_p;
	logic [TID_W-1:0]     pop_head, pop_head_n;
	ex_kind_t             ex_kind;

	out_item_t            res_q, out_q;
	logic                 out_valid_q;

	// Effective cohort count: zero counts as one, clamp at MAX_COHORTS
	always_comb begin
		if (num_coh_q == '0) begin
			n_eff = NCOH_W'(1);
		end else if (32'(num_coh_q) > 32'(MAX_COHORTS)) begin
			n_eff = NCOH_W'(MAX_COHORTS);
		end else begin
			n_eff = num_coh_q;
		end
	end

	// Remainder lanes for the requesting thread and the current holder
	always_comb begin
		rt_n = rt_q;
		rh_n = rh_q;
		for (int i = 0; i < MOD_STEP; i++) begin
			rt_n = mod_step(rt_n, divt_q[TID_W-1-i], n_eff);
			rh_n = mod_step(rh_n, divh_q[TID_W-1-i], n_eff);
		end
	end

	assign coh_c     = CW'(rt_q);
	assign coh_h     = CW'(rh_q);
	assign coh_d     = gq_rd_data;
	assign tidx      = TAW'(tid_q);
	assign t_bad     = 32'(tid_q) >= 32'(MAX_THREADS);
	assign is_holder = hv_q && (ht_q == tid_q);
	assign ne_c      = ne_q[coh_c];
	assign batch_c   = bcv_q[coh_c] ? coh_rd.batch : '0;
	assign batch_p   = bcv_q[pop_coh_q] ? coh_rd.batch : '0;
	assign gq_full   = gcnt_q >= CNTW'(MAX_COHORTS);
	assign gq_empty  = gcnt_q == '0;
	assign gd_ok     = (32'(coh_d) < 32'(MAX_COHORTS)) && ne_q[coh_d];
	assign out_free  = !out_valid_q || out_ready;
	assign pop_head  = coh_rd.head;
	assign pop_head_n = (coh_rd.head == coh_rd.tail) ? coh_rd.head : link_rd;

	always_comb begin
		if (op_q == OP_LOCK) begin
			if (t_bad || queued_q[tidx] || is_holder) begin
				ex_kind = EX_DUP;
			end else if (!hv_q) begin
				ex_kind = EX_GRANT;
			end else begin
				ex_kind = EX_QUEUE;
			end
		end else begin
			if (t_bad || !is_holder) begin
				ex_kind = EX_NON_HOLDER;
			end else if (ne_c && (batch_c < batch_lim_q)) begin
				ex_kind = EX_LOCAL;
			end else begin
				ex_kind = EX_RELEASE;
			end
		end
	end

	// Global FIFO pointers: write slot is read pointer plus count, wrapped
	assign wsum  = SW'(grp_q) + SW'(gcnt_q);
	assign wp    = (wsum >= SW'(MAX_COHORTS)) ? CW'(wsum - SW'(MAX_COHORTS)) : CW'(wsum);
	assign grp_n = (grp_q == CW'(MAX_COHORTS - 1)) ? '0 : grp_q + 1'b1;

	assign gq_we = cmd.exec && !gq_full &&
		(((ex_kind == EX_QUEUE) && !ne_c && (coh_c != coh_h)) ||
		((ex_kind == EX_RELEASE) && ne_c));
	assign gq_re = cmd.gq_rd && !gq_empty;

	assign coh_re    = cmd.coh_rd || (cmd.gq_chk && gd_ok);
	assign coh_raddr = cmd.coh_rd ? coh_c : coh_d;
	assign coh_we    = (cmd.exec && (ex_kind == EX_QUEUE)) || cmd.pop;
	assign coh_waddr = cmd.pop ? pop_coh_q : coh_c;

	always_comb begin
		if (cmd.pop) begin
			coh_wr.batch = pop_local_q ? batch_p + 1'b1 : '0;
			coh_wr.head  = pop_head_n;
			coh_wr.tail  = coh_rd.tail;
		end else begin
			coh_wr.batch = coh_rd.batch;
			coh_wr.head  = ne_c ? coh_rd.head : tid_q;
			coh_wr.tail  = tid_q;
		end
	end

	assign link_we = cmd.exec && (ex_kind == EX_QUEUE) && ne_c;
	assign link_re = (cmd.exec && (ex_kind == EX_LOCAL)) || cmd.link_rd;

	cbla_ram #(
		.WIDTH ($bits(coh_entry_t)),
		.DEPTH (MAX_COHORTS)
	) u_coh_ram (
		.clk   (clk),
		.we    (coh_we),
		.waddr (coh_waddr),
		.wdata (coh_wr),
		.re    (coh_re),
		.raddr (coh_raddr),
		.rdata (coh_rd)
	);

	cbla_ram #(
		.WIDTH (TID_W),
		.DEPTH (NTHR)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (TAW'(coh_rd.tail)),
		.wdata (tid_q),
		.re    (link_re),
		.raddr (TAW'(coh_rd.head)),
		.rdata (link_rd)
	);

	cbla_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_COHORTS)
	) u_gq_ram (
		.clk   (clk),
		.we    (gq_we),
		.waddr (wp),
		.wdata (coh_c),
		.re    (gq_re),
		.raddr (grp_q),
		.rdata (gq_rd_data)
	);

	// Control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_lim_q <= MB_W'(10);
			num_coh_q   <= NCOH_W'(2);
			hv_q        <= 1'b0;
			ht_q        <= '0;
			queued_q    <= '0;
			ne_q        <= '0;
			bcv_q       <= '0;
			grp_q       <= '0;
			gcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_BATCH_LIM:   batch_lim_q <= cfg_data;
					CFG_NUM_COHORTS: num_coh_q   <= cfg_data[NCOH_W-1:0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				case (ex_kind)
					EX_GRANT: begin
						hv_q         <= 1'b1;
						ht_q         <= tid_q;
						bcv_q[coh_c] <= 1'b0;
					end
					EX_QUEUE: begin
						ne_q[coh_c]    <= 1'b1;
						queued_q[tidx] <= 1'b1;
					end
					EX_RELEASE: hv_q <= 1'b0;
					default: ;
				endcase
			end
			if (gq_we) begin
				gcnt_q <= gcnt_q + 1'b1;
			end
			if (gq_re) begin
				grp_q  <= grp_n;
				gcnt_q <= gcnt_q - 1'b1;
			end
			if (cmd.pop) begin
				queued_q[TAW'(pop_head)] <= 1'b0;
				hv_q                     <= 1'b1;
				ht_q                     <= pop_head;
				bcv_q[pop_coh_q]         <= pop_local_q;
				if (coh_rd.head == coh_rd.tail) begin
					ne_q[pop_coh_q] <= 1'b0;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, remainder lanes, pop context and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= in_item.operation;
			tid_q     <= in_item.req_thread;
			divt_q    <= in_item.req_thread;
			divh_q    <= ht_q;
			rt_q      <= '0;
			rh_q      <= '0;
			mod_cnt_q <= '0;
		end else if (cmd.mod_step) begin
			divt_q    <= divt_q << MOD_STEP;
			divh_q    <= divh_q << MOD_STEP;
			rt_q      <= rt_n;
			rh_q      <= rh_n;
			mod_cnt_q <= mod_cnt_q + 1'b1;
		end
		if (cmd.exec && (ex_kind == EX_LOCAL)) begin
			pop_coh_q   <= coh_c;
			pop_local_q <= 1'b1;
		end else if (cmd.gq_chk && gd_ok) begin
			pop_coh_q   <= coh_d;
			pop_local_q <= 1'b0;
		end
		if (cmd.exec) begin
			res_q.grant_valid   <= 1'b0;
			res_q.grant_thread  <= '0;
			res_q.local_handoff <= 1'b0;
			case (ex_kind)
				EX_DUP:        res_q.outcome <= OUT_DUPLICATE;
				EX_NON_HOLDER: res_q.outcome <= OUT_NON_HOLDER;
				EX_QUEUE:      res_q.outcome <= OUT_QUEUED;
				EX_GRANT: begin
					res_q.outcome      <= OUT_GRANTED;
					res_q.grant_valid  <= 1'b1;
					res_q.grant_thread <= tid_q;
				end
				default: res_q.outcome <= OUT_UNLOCKED;
			endcase
		end else if (cmd.gq_rd && gq_empty) begin
			res_q.outcome       <= OUT_UNLOCKED;
			res_q.grant_valid   <= 1'b0;
			res_q.grant_thread  <= '0;
			res_q.local_handoff <= 1'b0;
		end else if (cmd.pop) begin
			res_q.outcome       <= OUT_UNLOCKED;
			res_q.grant_valid   <= 1'b1;
			res_q.grant_thread  <= pop_head;
			res_q.local_handoff <= pop_local_q;
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign status.mod_done = mod_cnt_q == MOD_CNT_W'(MOD_CYC - 1);
	assign status.ex_kind  = ex_kind;
	assign status.gq_empty = gq_empty;
	assign status.gd_ok    = gd_ok;
	assign status.out_free = out_free;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

>>> sv/cohort_batched_lock_arbiter_top.sv
// Top level of the cohort lock arbiter: controller, datapath and checks.
// Locks and rejected unlocks go straight to the result; a local handoff pops the
// holder's cohort; a release pops the first queued cohort that still has a waiter.
// The remainder unit (3 id bits a cycle) and registered reads of the cohort, link
// and cohort-queue RAMs lie on these paths. A transaction is taken only once the
// last result is in the output register. Async active-low reset frees the lock,
// empties all queues and loads a batch limit of 10 and 2 cohorts; no clearing pass.
`default_nettype none
`include "cohort_batched_lock_arbiter_top_defines.svh"

module cohort_batched_lock_arbiter_top import cbla_pkg::*; #(
	parameter int MAX_THREADS = 64,
	parameter int MAX_COHORTS = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [CFG_DAT_W-1:0] cfg_data,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire in_item_t       in_item,
	output logic                out_valid,
	input  wire                 out_ready,
	output out_item_t           out_item
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       out_local;
	logic       out_no_grant;
	logic       grant_clean;
	logic       out_err;

	assign cfg_ready = 1'b1;

	cbla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	cbla_dp #(
		.MAX_THREADS (MAX_THREADS),
		.MAX_COHORTS (MAX_COHORTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	assign out_local    = out_valid && out_item.local_handoff;
	assign out_no_grant = out_valid && !out_item.grant_valid;
	assign grant_clean  = (out_item.grant_thread == '0) && !out_item.local_handoff;
	assign out_err      = (out_item.outcome == OUT_QUEUED) ||
		(out_item.outcome == OUT_DUPLICATE) || (out_item.outcome == OUT_NON_HOLDER);

	`CBLA_ASSERT_IMPL(a_local_needs_grant, clk, arst_n, out_local, out_item.grant_valid)
	`CBLA_ASSERT_IMPL(a_no_grant_clean, clk, arst_n, out_no_grant, grant_clean)
	`CBLA_ASSERT_IMPL(a_err_no_grant, clk, arst_n, out_valid && out_err, !out_item.grant_valid)
	`CBLA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

>>> test/tb_cohort_batched_lock_arbiter_top.sv
// Self-checking testbench for the cohort lock arbiter: directed, random and backpressure tests.
`timescale 1ns / 1ps

module tb_cohort_batched_lock_arbiter_top;
	import cbla_pkg::*;

	localparam int THREAD_SLOTS   = 64;
	localparam int NUM_COHORTS    = 8;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int MAX_REPORTS    = 50;

	typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_MASK} rx_mode_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_item;

	// Lock state mirror
	logic [MB_W-1:0]   batch_limit;
	logic [NCOH_W-1:0] cohorts_cfg;
	logic              own_valid;
	logic [TID_W-1:0]  own_thread;
	logic              waiting [THREAD_SLOTS];
	logic [TID_W-1:0]  next_of [THREAD_SLOTS];
	logic [TID_W-1:0]  head_of [NUM_COHORTS];
	logic [TID_W-1:0]  tail_of [NUM_COHORTS];
	logic              coh_busy [NUM_COHORTS];
	logic [MB_W-1:0]   batch_of [NUM_COHORTS];
	logic [2:0]        ring [NUM_COHORTS];
	logic [2:0]        ring_rd;
	logic [3:0]        ring_cnt;

	out_item_t grants_due [$];
	out_item_t want;
	int        mismatch_count = 0;
	int        cycle_count    = 0;
	int        burst_left     = 0;
	bit        sender_steady  = 1'b0;

	bit        rx_hold_req   = 1'b0;
	int        rx_hold_left  = 0;
	int        rx_phase_left = 0;
	rx_mode_t  rx_mode       = RX_OPEN;
	logic [7:0] rx_mask      = 8'b1011_0010;

	cohort_batched_lock_arbiter_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [2:0] cohort_sel(input logic [TID_W-1:0] t);
		int n;
		n = cohorts_cfg;
		if (n < 1) n = 1;
		if (n > NUM_COHORTS) n = NUM_COHORTS;
		return 3'(t % n);
	endfunction

	function automatic logic [TID_W-1:0] waiter_pop(input logic [2:0] c);
		logic [TID_W-1:0] h;
		h = head_of[c];
		if (h == tail_of[c]) coh_busy[c] = 1'b0;
		else head_of[c] = next_of[h];
		waiting[h] = 1'b0;
		return h;
	endfunction

	function automatic void ring_push(input logic [2:0] c);
		logic [2:0] slot;
		slot = ring_rd + ring_cnt[2:0];
		if (ring_cnt < NUM_COHORTS) begin
			ring[slot] = c;
			ring_cnt++;
		end
	endfunction

	// Apply one transaction to the lock state and return the result it produces.
	function automatic out_item_t predict_grant(input in_item_t req);
		out_item_t        r;
		logic [TID_W-1:0] t;
		logic [2:0]       c;
		logic [2:0]       d;
		logic             was_empty;
		r = '0;
		t = req.req_thread;
		c = cohort_sel(t);
		if (req.operation == OP_LOCK) begin
			if (waiting[t] || (own_valid && own_thread == t)) begin
				r.outcome = OUT_DUPLICATE;
			end else if (!own_valid) begin
				own_valid = 1'b1;
				own_thread = t;
				batch_of[c] = '0;
				r.outcome = OUT_GRANTED;
				r.grant_valid = 1'b1;
				r.grant_thread = t;
			end else begin
				was_empty = !coh_busy[c];
				if (coh_busy[c]) begin
					next_of[tail_of[c]] = t;
				end else begin
					head_of[c] = t;
					coh_busy[c] = 1'b1;
				end
				tail_of[c] = t;
				waiting[t] = 1'b1;
				if (was_empty && c != cohort_sel(own_thread)) ring_push(c);
				r.outcome = OUT_QUEUED;
			end
		end else begin
			if (!own_valid || own_thread != t) begin
				r.outcome = OUT_NON_HOLDER;
			end else begin
				r.outcome = OUT_UNLOCKED;
				if (coh_busy[c] && batch_of[c] < batch_limit) begin
					batch_of[c] = batch_of[c] + 1'b1;
					own_thread = waiter_pop(c);
					r.grant_valid = 1'b1;
					r.grant_thread = own_thread;
					r.local_handoff = 1'b1;
				end else begin
					own_valid = 1'b0;
					if (coh_busy[c]) ring_push(c);
					// skip drained cohorts until one with a waiter comes up
					while (ring_cnt > 0 && !own_valid) begin
						d = ring[ring_rd];
						ring_rd = ring_rd + 1'b1;
						ring_cnt = ring_cnt - 1'b1;
						if (coh_busy[d]) begin
							own_thread = waiter_pop(d);
							own_valid = 1'b1;
							batch_of[d] = '0;
							r.grant_valid = 1'b1;
							r.grant_thread = own_thread;
						end
					end
				end
			end
		end
		return r;
	endfunction

	task automatic note_mismatch(input string field, input int exp_val, input int act_val);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$error("%s: expected %0d, got %0d", field, exp_val, act_val);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (grants_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$error("result with no transaction pending: outcome %0d", out_item.outcome);
			end else begin
				want = grants_due.pop_front();
				if (out_item.outcome !== want.outcome)
					note_mismatch("outcome", want.outcome, out_item.outcome);
				if (out_item.grant_valid !== want.grant_valid)
					note_mismatch("grant_valid", want.grant_valid, out_item.grant_valid);
				if (out_item.grant_thread !== want.grant_thread)
					note_mismatch("grant_thread", want.grant_thread, out_item.grant_thread);
				if (out_item.local_handoff !== want.local_handoff)
					note_mismatch("local_handoff", want.local_handoff, out_item.local_handoff);
			end
		end
	end

	// Receiver: switch among stall patterns, or hold off on request.
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			out_ready <= 1'b0;
			rx_hold_left--;
		end else if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_hold_left = RX_HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			if (rx_phase_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_phase_left = $urandom_range(10, 80);
				rx_mask = 8'($urandom) | 8'h01;
			end else begin
				rx_phase_left--;
			end
			case (rx_mode)
				RX_OPEN: out_ready <= 1'b1;
				RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default: begin
					out_ready <= rx_mask[0];
					rx_mask = {rx_mask[0], rx_mask[7:1]};
				end
			endcase
		end
	end

	// Drop valid and let the sender idle; call only at a falling edge.
	task automatic sender_rest(input int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_op(input logic op, input logic [TID_W-1:0] tid);
		in_item_t req;
		req.operation = op;
		req.req_thread = tid;
		in_item <= req;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		grants_due.push_back(predict_grant(req));
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if (!sender_steady && $urandom_range(0, 3) != 0)
				sender_rest($urandom_range(1, 8));
		end
	endtask

	task automatic wait_drained();
		sender_rest(1);
		while (grants_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_BATCH_LIM) batch_limit = val;
		else cohorts_cfg = val[NCOH_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly well-formed traffic: requests from a pool and unlocks by the holder.
	task automatic send_random_item(input int pool_hi);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45 || (pick < 85 && !own_valid))
			send_op(OP_LOCK, TID_W'($urandom_range(0, pool_hi)));
		else if (pick < 85)
			send_op(OP_UNLOCK, own_thread);
		else if (pick < 93)
			send_op(OP_UNLOCK, TID_W'($urandom));
		else
			send_op(OP_LOCK, own_valid ? own_thread : TID_W'($urandom));
	endtask

	task automatic test_basic_ops();
		send_op(OP_UNLOCK, 6'd0);
		send_op(OP_LOCK, 6'd0);
		send_op(OP_LOCK, 6'd0);
		send_op(OP_LOCK, 6'd63);
		send_op(OP_LOCK, 6'd63);
		send_op(OP_LOCK, 6'd2);
		send_op(OP_UNLOCK, 6'd63);
		send_op(OP_UNLOCK, 6'd0);
		send_op(OP_UNLOCK, 6'd2);
		send_op(OP_UNLOCK, 6'd63);
		wait_drained();
	endtask

	// No local handoffs: every release rotates through the cohort queue.
	task automatic test_batch_limit();
		cfg_write(CFG_BATCH_LIM, 8'd0);
		cfg_write(CFG_NUM_COHORTS, 8'd3);
		send_op(OP_LOCK, 6'd0);
		send_op(OP_LOCK, 6'd3);
		send_op(OP_LOCK, 6'd6);
		send_op(OP_LOCK, 6'd1);
		send_op(OP_LOCK, 6'd2);
		send_op(OP_UNLOCK, 6'd0);
		send_op(OP_UNLOCK, 6'd1);
		send_op(OP_UNLOCK, 6'd2);
		send_op(OP_UNLOCK, 6'd3);
		send_op(OP_UNLOCK, 6'd6);
		wait_drained();
	endtask

	task automatic test_cohort_count();
		cfg_write(CFG_BATCH_LIM, 8'd255);
		cfg_write(CFG_NUM_COHORTS, 8'd0);
		send_op(OP_LOCK, 6'd5);
		send_op(OP_LOCK, 6'd9);
		send_op(OP_UNLOCK, 6'd5);
		send_op(OP_UNLOCK, 6'd9);
		wait_drained();
		cfg_write(CFG_NUM_COHORTS, 8'd15);
		send_op(OP_LOCK, 6'd7);
		send_op(OP_LOCK, 6'd15);
		send_op(OP_LOCK, 6'd8);
		wait_drained();
		// change the mapping while threads are still waiting
		cfg_write(CFG_NUM_COHORTS, 8'd2);
		send_op(OP_UNLOCK, 6'd7);
		send_op(OP_UNLOCK, 6'd8);
		send_op(OP_LOCK, 6'd15);
		wait_drained();
	endtask

	task automatic run_traffic_phase(input logic [CFG_DAT_W-1:0] batch,
			input logic [CFG_DAT_W-1:0] cohorts, input int count, input int pool_hi);
		wait_drained();
		cfg_write(CFG_BATCH_LIM, batch);
		cfg_write(CFG_NUM_COHORTS, cohorts);
		repeat (count) send_random_item(pool_hi);
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(8'd10, 8'd2, 140, 15);
		sender_steady = 1'b1;
		run_traffic_phase(8'd0, 8'd1, 140, 63);
		sender_steady = 1'b0;
		run_traffic_phase(8'd255, 8'd8, 140, 63);
		run_traffic_phase(8'd1, 8'd3, 140, 11);
		run_traffic_phase(8'd3, 8'h10, 140, 7);
		sender_steady = 1'b1;
		run_traffic_phase(8'd2, 8'd15, 140, 31);
		sender_steady = 1'b0;
		run_traffic_phase(8'd255, 8'd5, 140, 63);
		run_traffic_phase(8'd4, 8'hF7, 140, 63);
		run_traffic_phase(8'd0, 8'd8, 140, 23);
		run_traffic_phase(CFG_DAT_W'($urandom), CFG_DAT_W'($urandom_range(0, 15)), 140, 63);
		wait_drained();
	endtask

	// Hold the receiver off while the sender keeps offering transactions.
	task automatic test_backpressure();
		wait_drained();
		rx_hold_req = 1'b1;
		sender_steady = 1'b1;
		repeat (40) send_random_item(15);
		sender_steady = 1'b0;
		wait_drained();
	endtask

	initial begin
		batch_limit = 8'd10;
		cohorts_cfg = 4'd2;
		own_valid = 1'b0;
		own_thread = '0;
		ring_rd = '0;
		ring_cnt = '0;
		for (int i = 0; i < THREAD_SLOTS; i++) begin
			waiting[i] = 1'b0;
			next_of[i] = '0;
		end
		for (int i = 0; i < NUM_COHORTS; i++) begin
			head_of[i] = '0;
			tail_of[i] = '0;
			coh_busy[i] = 1'b0;
			batch_of[i] = '0;
			ring[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_ops();
		test_batch_limit();
		test_cohort_count();
		test_backpressure();
		test_random_traffic();

		wait_drained();
		repeat (30) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
